// File: rtl/pq4_pkg.sv
package pq4_pkg;

  localparam int NUM_CENTROIDS_DEF  = 16;
  localparam int CENTROID_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF      = 48;

  localparam int VALUE_W = 16;
  localparam int CODE_W  = 8;
  localparam int DIST_W  = 32;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  localparam logic [1:0] MODE_L2   = 2'd0;
  localparam logic [1:0] MODE_COS  = 2'd1;
  localparam logic [1:0] MODE_NCOS = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFF;
  localparam int ONE_Q24 = 32'h0100_0000;

  typedef struct packed {
    logic capture;
    logic half;
    logic rd;
    logic mul;
    logic acc;
    logic mul_ld;
    logic mul_step;
    logic sq_init;
    logic sq_l2;
    logic sq_step;
    logic div_ld;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       last;
    logic       g_zero;
  } ctrl_stat_t;

endpackage

// File: rtl/pq4_ctrl.sv
module pq4_ctrl #(
  parameter int ACC_WIDTH = pq4_pkg::ACC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  output pq4_pkg::ctrl_cmd_t cmd,
  input  pq4_pkg::ctrl_stat_t stat
);

  localparam int DIV_STEPS = ACC_WIDTH + 16;
  localparam int CNW       = $clog2(DIV_STEPS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_MLD   = 4'd4;
  localparam logic [3:0] S_MSTEP = 4'd5;
  localparam logic [3:0] S_SINIT = 4'd6;
  localparam logic [3:0] S_SSTEP = 4'd7;
  localparam logic [3:0] S_DLD   = 4'd8;
  localparam logic [3:0] S_DSTEP = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]     state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           half_r, half_nxt;
  logic           oval_r, oval_nxt;
  logic           accept, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = oval_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !oval_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    half_nxt  = half_r;
    oval_nxt  = oval_r && out_stall;
    cmd       = '0;
    cmd.half  = half_r;
    cmd.sq_l2 = (stat.mode != pq4_pkg::MODE_COS);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          half_nxt    = 1'b0;
          if (in_cmd == pq4_pkg::CMD_COMPARE) state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = S_RD;
        end else if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.mode == pq4_pkg::MODE_COS) begin
          state_nxt = S_MLD;
        end else if (stat.mode == pq4_pkg::MODE_NCOS) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SINIT;
        end
      end
      S_MLD: begin
        cmd.mul_ld = 1'b1;
        cnt_nxt    = CNW'(ACC_WIDTH);
        state_nxt  = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) state_nxt = S_SINIT;
      end
      S_SINIT: begin
        cmd.sq_init = 1'b1;
        cnt_nxt     = CNW'(ACC_WIDTH);
        state_nxt   = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          state_nxt = (stat.mode == pq4_pkg::MODE_COS) ? S_DLD : S_FIN;
        end
      end
      S_DLD: begin
        // skip the divide when the norm product is zero
        if (stat.g_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_ld = 1'b1;
          cnt_nxt    = CNW'(DIV_STEPS);
          state_nxt  = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          oval_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      half_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      half_r  <= half_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// File: rtl/pq4_dpath.sv
module pq4_dpath #(
  parameter int NUM_CENTROIDS  = pq4_pkg::NUM_CENTROIDS_DEF,
  parameter int CENTROID_WIDTH = pq4_pkg::CENTROID_WIDTH_DEF,
  parameter int ACC_WIDTH      = pq4_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pq4_pkg::ctrl_cmd_t                cmd,
  output pq4_pkg::ctrl_stat_t               stat,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_wr_data,
  input  logic                              in_cmd,
  input  logic [3:0]                        in_centroid_index,
  input  logic signed [pq4_pkg::VALUE_W-1:0] in_centroid_value,
  input  logic [pq4_pkg::CODE_W-1:0]        in_code_a,
  input  logic [pq4_pkg::CODE_W-1:0]        in_code_b,
  input  logic                              in_last,
  output logic [pq4_pkg::DIST_W-1:0]        out_distance,
  output logic                              out_zero_norm
);

  localparam int W   = ACC_WIDTH;
  localparam int N   = ACC_WIDTH + 16;
  localparam int VW  = pq4_pkg::VALUE_W;
  localparam int CWE = (CENTROID_WIDTH < VW) ? CENTROID_WIDTH : VW;
  localparam int IW  = $clog2(NUM_CENTROIDS);

  logic signed [CWE-1:0] tbl [NUM_CENTROIDS];

  logic [1:0]                mode_r;
  logic [pq4_pkg::CODE_W-1:0] code_a_r, code_b_r;
  logic                      last_r;
  logic signed [VW-1:0]      fa_r, fb_r;
  logic [31:0]               sqd_r, sqa_r, sqb_r;
  logic signed [31:0]        dotp_r;
  logic [W-1:0]              ssd_r, na_r, nb_r;
  logic signed [W-1:0]       dot_r;
  logic [W-1:0]              a_r, b_r, root_r;
  logic [2*W-1:0]            prod_r;
  logic [W+1:0]              rem_r;
  logic [pq4_pkg::DIST_W-1:0] dist_r;
  logic                      zn_r;

  logic [3:0]         nib_a, nib_b;
  logic signed [16:0] diff;
  logic signed [33:0] dsq;
  logic [W:0]         s_ssd, s_na, s_nb;
  logic signed [W:0]  s_dot;
  logic [W-1:0]       ssd_nxt, na_nxt, nb_nxt;
  logic signed [W-1:0] dot_nxt;
  logic [W+1:0]       sq_rsh, sq_trial;
  logic [W:0]         dv_rsh;
  logic               dv_ge;
  logic [W-1:0]       dot_mag;

  logic signed [W+1:0] nd;
  logic [W+1:0]        nm;
  logic [pq4_pkg::DIST_W-1:0] l2_v, ncos_v, cos_v, dist_nxt;
  logic [N-1:0]        q;
  logic [33:0]         qt;
  logic                g_zero;

  assign stat.mode   = mode_r;
  assign stat.last   = last_r;
  assign stat.g_zero = g_zero;
  assign g_zero      = (root_r == '0);

  assign out_distance  = dist_r;
  assign out_zero_norm = zn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pq4_pkg::MODE_L2;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // centroid table: write on a load transfer, registered read per nibble
  assign nib_a = cmd.half ? code_a_r[7:4] : code_a_r[3:0];
  assign nib_b = cmd.half ? code_b_r[7:4] : code_b_r[3:0];

  always_ff @(posedge clk) begin
    if (cmd.capture && in_cmd == pq4_pkg::CMD_LOAD &&
        32'(in_centroid_index) < NUM_CENTROIDS) begin
      tbl[in_centroid_index[IW-1:0]] <= in_centroid_value[CWE-1:0];
    end
    if (cmd.rd) begin
      fa_r <= (32'(nib_a) < NUM_CENTROIDS) ? VW'(tbl[nib_a[IW-1:0]]) : '0;
      fb_r <= (32'(nib_b) < NUM_CENTROIDS) ? VW'(tbl[nib_b[IW-1:0]]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && in_cmd == pq4_pkg::CMD_COMPARE) begin
      code_a_r <= in_code_a;
      code_b_r <= in_code_b;
      last_r   <= in_last;
    end
  end

  assign diff = 17'(fa_r) - 17'(fb_r);
  assign dsq  = 34'(diff) * 34'(diff);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sqd_r  <= dsq[31:0];
      sqa_r  <= $unsigned(32'(fa_r) * 32'(fa_r));
      sqb_r  <= $unsigned(32'(fb_r) * 32'(fb_r));
      dotp_r <= 32'(fa_r) * 32'(fb_r);
    end
  end

  // saturating accumulate
  always_comb begin
    s_ssd   = (W+1)'(ssd_r) + (W+1)'(sqd_r);
    s_na    = (W+1)'(na_r) + (W+1)'(sqa_r);
    s_nb    = (W+1)'(nb_r) + (W+1)'(sqb_r);
    s_dot   = (W+1)'(dot_r) + (W+1)'(dotp_r);
    ssd_nxt = s_ssd[W] ? '1 : s_ssd[W-1:0];
    na_nxt  = s_na[W] ? '1 : s_na[W-1:0];
    nb_nxt  = s_nb[W] ? '1 : s_nb[W-1:0];
    if (s_dot[W] != s_dot[W-1]) begin
      dot_nxt = s_dot[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      dot_nxt = s_dot[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      ssd_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      dot_r <= '0;
    end else if (cmd.acc) begin
      ssd_r <= ssd_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
      dot_r <= dot_nxt;
    end
  end

  // back end: shift-add multiply, digit-by-digit root, restoring divide
  assign sq_rsh   = {rem_r[W-1:0], prod_r[2*W-1 -: 2]};
  assign sq_trial = {root_r, 2'b01};
  assign dv_rsh   = {rem_r[W-1:0], prod_r[N-1]};
  assign dv_ge    = (dv_rsh >= {1'b0, root_r});
  assign dot_mag  = dot_r[W-1] ? $unsigned(-dot_r) : $unsigned(dot_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      a_r    <= na_r;
      b_r    <= nb_r;
      prod_r <= '0;
    end else if (cmd.mul_step) begin
      prod_r <= {prod_r[2*W-2:0], 1'b0} + (b_r[W-1] ? (2*W)'(a_r) : '0);
      b_r    <= {b_r[W-2:0], 1'b0};
    end else if (cmd.sq_init) begin
      if (cmd.sq_l2) prod_r <= (2*W)'(ssd_r) << 8;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sq_step) begin
      prod_r <= {prod_r[2*W-3:0], 2'b00};
      if (sq_rsh >= sq_trial) begin
        rem_r  <= sq_rsh - sq_trial;
        root_r <= {root_r[W-2:0], 1'b1};
      end else begin
        rem_r  <= sq_rsh;
        root_r <= {root_r[W-2:0], 1'b0};
      end
    end else if (cmd.div_ld) begin
      prod_r <= (2*W)'(dot_mag) << 16;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= (W+2)'(dv_ge ? dv_rsh - {1'b0, root_r} : dv_rsh);
      prod_r <= {prod_r[2*W-2:0], dv_ge};
    end
  end

  // result formatting
  always_comb begin
    l2_v = (root_r > W'(pq4_pkg::DIST_MAX)) ? pq4_pkg::DIST_MAX : root_r[31:0];

    nd = (W+2)'(pq4_pkg::ONE_Q24) - (W+2)'(dot_r);
    nm = nd[W+1] ? $unsigned(-nd) : $unsigned(nd);
    nm = nm >> 8;
    ncos_v = (nm > (W+2)'(pq4_pkg::DIST_MAX)) ? pq4_pkg::DIST_MAX : nm[31:0];

    q = prod_r[N-1:0];
    if (dot_r[W-1]) begin
      qt = {1'b0, q[32:0]} + 34'h1_0000;
    end else if (q[32:16] != '0) begin
      qt = {1'b0, q[32:0]} - 34'h1_0000;
    end else begin
      qt = 34'h1_0000 - {1'b0, q[32:0]};
    end
    if (q[N-1:33] != '0 || qt[33:32] != 2'b00) begin
      cos_v = pq4_pkg::DIST_MAX;
    end else begin
      cos_v = qt[31:0];
    end

    case (mode_r)
      pq4_pkg::MODE_COS:  dist_nxt = g_zero ? '0 : cos_v;
      pq4_pkg::MODE_NCOS: dist_nxt = ncos_v;
      default:            dist_nxt = l2_v;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dist_r <= dist_nxt;
      zn_r   <= (mode_r == pq4_pkg::MODE_COS) && g_zero;
    end
  end

endmodule

// File: rtl/pq4_codebook_distance.sv
// Load item: written on transfer, next item taken in the following cycle.
// Compare item: two table reads each followed by multiply and accumulate.
// Last item adds the back end: L2 a serial root, normalised cosine only the finish step,
// cosine a serial multiply, root, then divide.
// Result waits in an output register; the next item is taken meanwhile.
// Synchronous active-low reset clears mode, accumulators and control; table undefined.
module pq4_codebook_distance #(
  parameter int NUM_CENTROIDS  = pq4_pkg::NUM_CENTROIDS_DEF,
  parameter int CENTROID_WIDTH = pq4_pkg::CENTROID_WIDTH_DEF,
  parameter int ACC_WIDTH      = pq4_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [3:0]                        in_centroid_index,
  input  logic signed [pq4_pkg::VALUE_W-1:0] in_centroid_value,
  input  logic [pq4_pkg::CODE_W-1:0]        in_code_a,
  input  logic [pq4_pkg::CODE_W-1:0]        in_code_b,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pq4_pkg::DIST_W-1:0]        out_distance,
  output logic                              out_zero_norm,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_wr_data
);

  pq4_pkg::ctrl_cmd_t  cmd;
  pq4_pkg::ctrl_stat_t stat;

  pq4_ctrl #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  pq4_dpath #(
    .NUM_CENTROIDS  (NUM_CENTROIDS),
    .CENTROID_WIDTH (CENTROID_WIDTH),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_cmd            (in_cmd),
    .in_centroid_index (in_centroid_index),
    .in_centroid_value (in_centroid_value),
    .in_code_a         (in_code_a),
    .in_code_b         (in_code_b),
    .in_last           (in_last),
    .out_distance      (out_distance),
    .out_zero_norm     (out_zero_norm)
  );

endmodule

// File: rtl/pq4_checker.sv
module pq4_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [pq4_pkg::DIST_W-1:0] out_distance,
  input logic                       out_zero_norm
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance) && $stable(out_zero_norm))
    else $error("stalled result changed");

  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_distance == '0)
    else $error("zero norm flagged with nonzero distance");

  a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == pq4_pkg::CMD_COMPARE |=> in_stall)
    else $error("compare transfer not followed by busy");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while busy");

endmodule

bind pq4_codebook_distance pq4_checker u_chk (.*);
